>>> src/vpr_pkg.sv
// Package: shared types, constants and CORDIC tables of the vector polar/rect unit.
`default_nettype none
package vpr_pkg;

    localparam int COORD_W = 16;
    localparam int ANGLE_W = 16;
    localparam int GUARD_W = 16;
    localparam int FRAC_W  = 8;
    localparam int XW      = 36;   // CORDIC x/y datapath
    localparam int ZW      = 34;   // CORDIC angle accumulator, 32-bit turn
    localparam int KW      = 31;   // gain in Q1.30

    localparam logic [2:0] CMD_P2R = 3'd0;
    localparam logic [2:0] CMD_R2P = 3'd1;
    localparam logic [2:0] CMD_ADD = 3'd2;
    localparam logic [2:0] CMD_SUB = 3'd3;
    localparam logic [2:0] CMD_NEG = 3'd4;
    localparam logic [2:0] CMD_SCL = 3'd5;

    localparam logic [1:0] CLS_DIRECT = 2'd0;
    localparam logic [1:0] CLS_ROT    = 2'd1;
    localparam logic [1:0] CLS_VEC    = 2'd2;

    typedef struct packed {
        logic [2:0]                command;
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic [COORD_W-1:0]        magnitude_in;
        logic [ANGLE_W-1:0]        angle_in;
        logic signed [COORD_W-1:0] factor;
    } in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] rx;
        logic signed [COORD_W-1:0] ry;
        logic [COORD_W-1:0]        magnitude_out;
        logic [ANGLE_W-1:0]        angle_out;
        logic                      overflow;
    } out_t;

    // Classified beat passed from front to back
    typedef struct packed {
        logic [1:0]           cls;
        logic                 zero;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        out_t                 res;
    } work_t;

    // Saturate to coordinate range; bit COORD_W is the overflow flag
    function automatic logic [COORD_W:0] sat(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        hi = XW'(32767);
        lo = -hi - XW'(1);
        if (v > hi)
            sat = {1'b1, 16'sh7FFF};
        else if (v < lo)
            sat = {1'b1, 16'sh8000};
        else
            sat = {1'b0, v[COORD_W-1:0]};
    endfunction

    // atan(2^-i) in a 32-bit turn, rounded to nearest
    function automatic logic [31:0] atan_turn(input int i);
        case (i)
            0: atan_turn = 32'd536870912;   1: atan_turn = 32'd316933406;
            2: atan_turn = 32'd167458907;   3: atan_turn = 32'd85004756;
            4: atan_turn = 32'd42667331;    5: atan_turn = 32'd21354465;
            6: atan_turn = 32'd10679838;    7: atan_turn = 32'd5340245;
            8: atan_turn = 32'd2670163;     9: atan_turn = 32'd1335087;
            10: atan_turn = 32'd667544;     11: atan_turn = 32'd333772;
            12: atan_turn = 32'd166886;     13: atan_turn = 32'd83443;
            14: atan_turn = 32'd41722;      15: atan_turn = 32'd20861;
            16: atan_turn = 32'd10430;      17: atan_turn = 32'd5215;
            18: atan_turn = 32'd2608;       19: atan_turn = 32'd1304;
            20: atan_turn = 32'd652;        21: atan_turn = 32'd326;
            22: atan_turn = 32'd163;        23: atan_turn = 32'd81;
            24: atan_turn = 32'd41;         25: atan_turn = 32'd20;
            26: atan_turn = 32'd10;         27: atan_turn = 32'd5;
            28: atan_turn = 32'd3;          29: atan_turn = 32'd1;
            30: atan_turn = 32'd1;
            default: atan_turn = 32'd0;
        endcase
    endfunction

    // Integer square root, elaboration only
    function automatic logic [63:0] isqrt(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = n_in;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int j = 0; j < 32; j++)
            if (b > n)
                b = b >> 2;
        for (int j = 0; j < 32; j++) begin
            if (b != 64'd0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end
                else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        isqrt = r;
    endfunction

    // Restoring long division, elaboration only
    function automatic logic [63:0] ldiv(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] q;
        rem = 65'd0;
        q = 64'd0;
        for (int j = 63; j >= 0; j--) begin
            rem = {rem[63:0], num[j]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                q[j] = 1'b1;
            end
        end
        ldiv = q;
    endfunction

    // CORDIC gain compensation in Q1.30
    function automatic logic [KW-1:0] gain(input int stages);
        logic [63:0] k;
        logic [63:0] t;
        logic [63:0] d;
        k = 64'd1 << 30;
        for (int i = 0; i < 32; i++) begin
            if (i < stages) begin
                t = (64'd1 << 60) + (64'd1 << (60 - 2 * i));
                d = isqrt(t);
                k = ldiv((k << 30) + (d >> 1), d);
            end
        end
        gain = k[KW-1:0];
    endfunction

endpackage
`default_nettype wire

>>> src/vpr_front.sv
// Front: accepts commands, classifies them and does the short operations.
`default_nettype none
module vpr_front #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire vpr_pkg::in_t  request,
    input  wire logic          q_full,
    output logic               busy,
    output logic               push,
    output vpr_pkg::work_t     work
);
    import vpr_pkg::*;

    localparam logic [KW-1:0] K = gain(CORDIC_STAGES);

    logic          valid_reg, valid_next;
    work_t         work_reg, work_next;
    logic [62:0]   mprod;
    logic [32:0]   x0;
    logic signed [31:0] sprod_x, sprod_y;
    logic signed [XW-1:0] vx, vy;
    logic [COORD_W:0] sx, sy;
    logic          take;

    assign busy = valid_reg && q_full;
    assign take = start && !busy;
    assign push = valid_reg && !q_full;
    assign work = work_reg;

    // Gain-compensated start magnitude and scale products
    always_comb
    begin
        mprod   = 63'({request.magnitude_in, 16'b0}) * 63'(K);
        x0      = 33'((mprod + 63'(1 << 29)) >> 30);
        sprod_x = 32'(request.ax) * 32'(request.factor);
        sprod_y = 32'(request.ay) * 32'(request.factor);
    end

    // Classify and evaluate direct ops
    always_comb
    begin
        vx = '0;
        vy = '0;
        work_next = '0;
        unique case (request.command)
            CMD_P2R:
            begin
                work_next.cls = CLS_ROT;
                work_next.x   = XW'(x0);
                work_next.z   = ZW'(signed'({request.angle_in, 16'b0}));
            end
            CMD_R2P:
            begin
                work_next.cls  = CLS_VEC;
                work_next.x    = XW'(request.ax) <<< GUARD_W;
                work_next.y    = XW'(request.ay) <<< GUARD_W;
                work_next.zero = (request.ax == '0) && (request.ay == '0);
            end
            CMD_ADD:
            begin
                vx = XW'(request.ax) + XW'(request.bx);
                vy = XW'(request.ay) + XW'(request.by);
            end
            CMD_SUB:
            begin
                vx = XW'(request.ax) - XW'(request.bx);
                vy = XW'(request.ay) - XW'(request.by);
            end
            CMD_NEG:
            begin
                vx = -XW'(request.ax);
                vy = -XW'(request.ay);
            end
            CMD_SCL:
            begin
                vx = (XW'(sprod_x) + XW'(1 << (FRAC_W - 1))) >>> FRAC_W;
                vy = (XW'(sprod_y) + XW'(1 << (FRAC_W - 1))) >>> FRAC_W;
            end
            default:
            begin
                vx = '0;
                vy = '0;
            end
        endcase
        sx = sat(vx);
        sy = sat(vy);
        if (work_next.cls == CLS_DIRECT)
        begin
            work_next.res.rx       = sx[COORD_W-1:0];
            work_next.res.ry       = sy[COORD_W-1:0];
            work_next.res.overflow = sx[COORD_W] | sy[COORD_W];
        end
    end

    // Hold the beat until the queue takes it
    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (push)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            work_reg <= work_next;
    end

endmodule
`default_nettype wire

>>> src/vpr_queue.sv
// Two-entry queue between front and back.
`default_nettype none
module vpr_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire vpr_pkg::work_t wdata,
    output logic                full,
    output logic                head_valid,
    output vpr_pkg::work_t      head
);
    import vpr_pkg::*;

    work_t      mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign pop        = head_valid;
    assign head       = mem_reg[rp_reg];

    // Advance pointers; the back drains one beat per cycle
    always_comb
    begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ pop;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wdata;
    end

endmodule
`default_nettype wire

>>> src/vpr_back.sv
// Back: CORDIC pipeline, gain multiply and output rounding.
`default_nettype none
module vpr_back #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire vpr_pkg::work_t in_work,
    output logic                done,
    output vpr_pkg::out_t       result
);
    import vpr_pkg::*;

    localparam logic [KW-1:0] K = gain(CORDIC_STAGES);
    localparam int PW = 35 + KW;

    work_t st_reg [CORDIC_STAGES+1];
    logic  v_reg  [CORDIC_STAGES+1];
    work_t pre_next;

    // Pre-rotation into the right half plane
    always_comb
    begin
        pre_next = in_work;
        if (in_work.cls == CLS_ROT)
        begin
            if (in_work.z > ZW'(1 << 30) || in_work.z < -ZW'(1 << 30))
            begin
                pre_next.x = -in_work.x;
                pre_next.z = (in_work.z > 0) ? in_work.z - (ZW'(1) <<< 31)
                                             : in_work.z + (ZW'(1) <<< 31);
            end
        end
        else if (in_work.cls == CLS_VEC)
        begin
            pre_next.z = '0;
            if (in_work.x < 0)
            begin
                pre_next.x = -in_work.x;
                pre_next.y = -in_work.y;
                pre_next.z = ZW'(1) <<< 31;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        st_reg[0] <= pre_next;
    end

    // One micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        work_t s_next;
        logic  neg_dir;
        always_comb
        begin
            s_next  = st_reg[i];
            neg_dir = (st_reg[i].cls == CLS_ROT) ? (st_reg[i].z >= 0) : (st_reg[i].y < 0);
            if (neg_dir)
            begin
                s_next.x = st_reg[i].x - (st_reg[i].y >>> i);
                s_next.y = st_reg[i].y + (st_reg[i].x >>> i);
                s_next.z = st_reg[i].z - ZW'(atan_turn(i));
            end
            else
            begin
                s_next.x = st_reg[i].x + (st_reg[i].y >>> i);
                s_next.y = st_reg[i].y - (st_reg[i].x >>> i);
                s_next.z = st_reg[i].z + ZW'(atan_turn(i));
            end
            if (st_reg[i].cls == CLS_DIRECT)
                s_next = st_reg[i];
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else
                v_reg[i+1] <= v_reg[i];
        end
        always_ff @(posedge clk)
        begin
            st_reg[i+1] <= s_next;
        end
    end

    work_t       fin;
    out_t        a_next, a_reg, b_next, b_reg;
    logic [PW-1:0] prod_next, prod_reg;
    logic [1:0]  cls_reg;
    logic        zero_reg;
    logic        va_reg, vb_reg;
    logic [COORD_W:0] sx, sy;
    logic [32:0] zr;
    logic [34:0] xm;
    logic [PW-1:0] m1;
    logic [PW-1:0] m2;

    assign fin = st_reg[CORDIC_STAGES];

    // Round coordinates and angle, start the gain multiply
    always_comb
    begin
        a_next = fin.res;
        sx = sat((fin.x + XW'(1 << (GUARD_W - 1))) >>> GUARD_W);
        sy = sat((fin.y + XW'(1 << (GUARD_W - 1))) >>> GUARD_W);
        xm = (fin.x < 0) ? '0 : fin.x[34:0];
        prod_next = PW'(xm) * PW'(K);
        zr = {1'b0, fin.z[31:0]} + 33'(1 << 15);
        if (fin.cls == CLS_ROT)
        begin
            a_next = '0;
            a_next.rx = sx[COORD_W-1:0];
            a_next.ry = sy[COORD_W-1:0];
            a_next.overflow = sx[COORD_W] | sy[COORD_W];
        end
        else if (fin.cls == CLS_VEC)
        begin
            a_next = '0;
            a_next.angle_out = fin.zero ? '0 : zr[31:16];
        end
    end

    // Finish magnitude rounding and clamp
    always_comb
    begin
        b_next = a_reg;
        m1 = (prod_reg + PW'(1 << 29)) >> 30;
        m2 = (m1 + PW'(1 << 15)) >> 16;
        if (cls_reg == CLS_VEC && !zero_reg)
            b_next.magnitude_out = (m2 > PW'(16'hFFFF)) ? 16'hFFFF : m2[COORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= v_reg[CORDIC_STAGES];
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        prod_reg <= prod_next;
        cls_reg  <= fin.cls;
        zero_reg <= fin.zero;
        b_reg    <= b_next;
    end

    assign done   = vb_reg;
    assign result = b_reg;

endmodule
`default_nettype wire

>>> src/vector_polar_rect_unit.sv
// Top level of the vector polar/rect unit.
//
//  channel   | handshake      | payload
//  ----------+----------------+----------------------
//  command   | start / busy   | request (vpr_pkg::in_t)
//  result    | done strobe    | result  (vpr_pkg::out_t)
//
// One command per cycle while busy is low; each taken beat passes the front and
// the queue, then the unrolled CORDIC pipeline and the gain multiply to a result.
// The back drains the queue every cycle, so busy stays low in practice.
// Reset clears all valid flags; the result strobe cannot be held off.
`default_nettype none
module vector_polar_rect_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire vpr_pkg::in_t  request,
    output logic               done,
    output vpr_pkg::out_t      result
);
    import vpr_pkg::*;

    logic  q_full, push, head_valid;
    work_t fw, head;

    vpr_front #(.CORDIC_STAGES(CORDIC_STAGES)) u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .request(request),
        .q_full(q_full), .busy(busy), .push(push), .work(fw)
    );

    vpr_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .wdata(fw),
        .full(q_full), .head_valid(head_valid), .head(head)
    );

    vpr_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(head_valid), .in_work(head),
        .done(done), .result(result)
    );

endmodule
`default_nettype wire

>>> src/vpr_checker.sv
// Port-level checker for the vector polar/rect unit, with its bind.
`default_nettype none
module vpr_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          busy,
    input wire logic          done,
    input wire vpr_pkg::out_t result
);
    import vpr_pkg::*;

    // The back drains every beat, so the unit never pushes back
    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // A magnitude result carries no coordinate result
    a_polar_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.magnitude_out != '0) |->
            (result.rx == '0) && (result.ry == '0) && !result.overflow)
        else $error("magnitude with coordinates");

    // Overflow only on a saturated coordinate
    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.overflow |->
            (result.rx == 16'sh7FFF) || (result.rx == 16'sh8000) ||
            (result.ry == 16'sh7FFF) || (result.ry == 16'sh8000))
        else $error("overflow without saturation");

    // No result strobe straight out of reset
    a_reset_quiet: assert property (@(posedge clk) $rose(rst_n) |-> !done)
        else $error("done after reset");

endmodule

bind vector_polar_rect_unit vpr_checker u_vpr_checker (
    .clk(clk), .rst_n(rst_n), .busy(busy),
    .done(done), .result(result)
);
`default_nettype wire
